// File: design/fpexp_pkg.sv
// Shared types, constants, reciprocal factorial table and microcode program for the exp unit.
package fpexp_pkg;

    localparam int TABLE_LEN = 19;
    localparam int K_W       = 5;
    localparam int PC_W      = 4;
    localparam int MUL_W     = 33;
    localparam int PP_W      = 66;
    localparam int ACC_W     = 92;
    localparam int SUM_W     = 40;
    localparam int X_W       = 32;
    localparam int P_W       = 64;
    localparam int RES_W     = 31;

    localparam logic signed [X_W-1:0] X_LIMIT         = 32'sd1342177280;
    localparam logic [63:0]           ONE_Q23         = 64'h0000_0000_0080_0000;
    localparam logic [63:0]           ROUND_Q58_TO_Q23 = 64'h0000_0004_0000_0000;
    localparam logic signed [63:0]    STOP_THRESHOLD  = 64'sh0000_1A36_E2EB_4000;
    localparam logic signed [63:0]    P_ROUND         = 64'sd8192;

    localparam logic [PC_W-1:0] LOOP_PC = 4'd5;
    localparam logic [PC_W-1:0] DONE_PC = 4'd14;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PINIT,
        OP_SUMINIT,
        OP_TERM,
        OP_PUPD
    } op_t;

    typedef enum logic {
        A_LO,
        A_HI
    } a_sel_t;

    typedef enum logic [1:0] {
        B_X,
        B_TLO,
        B_THI
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        SH0,
        SH32,
        SH64
    } acc_sh_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_TERM,
        J_END
    } jmp_t;

    typedef struct packed {
        op_t     op;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        acc_sh_t acc_sh;
        jmp_t    jmp;
    } ucode_t;

    typedef struct packed {
        logic            load_x;
        logic            load_out;
        logic [K_W-1:0]  term_idx;
        ucode_t          uc;
    } dp_ctrl_t;

    typedef struct packed {
        logic small_term;
    } dp_stat_t;

    localparam ucode_t UC_IDLE = '{op: OP_NOP, a_sel: A_LO, b_sel: B_X,
                                   acc_op: ACC_HOLD, acc_sh: SH0, jmp: J_END};

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = UC_IDLE;
        unique case (pc)
            4'd0:  w = '{op: OP_PINIT, a_sel: A_LO, b_sel: B_X,
                        acc_op: ACC_HOLD, acc_sh: SH0, jmp: J_NEXT};
            4'd1:  w = '{op: OP_SUMINIT, a_sel: A_LO, b_sel: B_X,
                        acc_op: ACC_HOLD, acc_sh: SH0, jmp: J_NEXT};
            4'd2:  w = '{op: OP_NOP, a_sel: A_HI, b_sel: B_X,
                        acc_op: ACC_CLR, acc_sh: SH0, jmp: J_NEXT};
            4'd3:  w = '{op: OP_NOP, a_sel: A_LO, b_sel: B_X,
                        acc_op: ACC_ADD, acc_sh: SH32, jmp: J_NEXT};
            4'd4:  w = '{op: OP_PUPD, a_sel: A_LO, b_sel: B_X,
                        acc_op: ACC_HOLD, acc_sh: SH0, jmp: J_NEXT};
            4'd5:  w = '{op: OP_NOP, a_sel: A_LO, b_sel: B_TLO,
                        acc_op: ACC_HOLD, acc_sh: SH0, jmp: J_NEXT};
            4'd6:  w = '{op: OP_NOP, a_sel: A_LO, b_sel: B_THI,
                        acc_op: ACC_CLR, acc_sh: SH0, jmp: J_NEXT};
            4'd7:  w = '{op: OP_NOP, a_sel: A_HI, b_sel: B_TLO,
                        acc_op: ACC_ADD, acc_sh: SH32, jmp: J_NEXT};
            4'd8:  w = '{op: OP_NOP, a_sel: A_HI, b_sel: B_THI,
                        acc_op: ACC_ADD, acc_sh: SH32, jmp: J_NEXT};
            4'd9:  w = '{op: OP_NOP, a_sel: A_LO, b_sel: B_X,
                        acc_op: ACC_ADD, acc_sh: SH64, jmp: J_NEXT};
            4'd10: w = '{op: OP_TERM, a_sel: A_LO, b_sel: B_X,
                        acc_op: ACC_HOLD, acc_sh: SH0, jmp: J_NEXT};
            4'd11: w = '{op: OP_NOP, a_sel: A_HI, b_sel: B_X,
                        acc_op: ACC_CLR, acc_sh: SH0, jmp: J_NEXT};
            4'd12: w = '{op: OP_NOP, a_sel: A_LO, b_sel: B_X,
                        acc_op: ACC_ADD, acc_sh: SH32, jmp: J_NEXT};
            4'd13: w = '{op: OP_PUPD, a_sel: A_LO, b_sel: B_X,
                        acc_op: ACC_HOLD, acc_sh: SH0, jmp: J_TERM};
            4'd14: w = UC_IDLE;
            default: w = UC_IDLE;
        endcase
        return w;
    endfunction

    function automatic logic [63:0] inv_fact_q63(input logic [K_W-1:0] k);
        logic [63:0] v;
        v = 64'd0;
        unique case (k)
            5'd0:  v = 64'd4611686018427387904;
            5'd1:  v = 64'd1537228672809129301;
            5'd2:  v = 64'd384307168202282325;
            5'd3:  v = 64'd76861433640456465;
            5'd4:  v = 64'd12810238940076077;
            5'd5:  v = 64'd1830034134296582;
            5'd6:  v = 64'd228754266787072;
            5'd7:  v = 64'd25417140754119;
            5'd8:  v = 64'd2541714075411;
            5'd9:  v = 64'd231064915946;
            5'd10: v = 64'd19255409662;
            5'd11: v = 64'd1481185358;
            5'd12: v = 64'd105798954;
            5'd13: v = 64'd7053264;
            5'd14: v = 64'd440829;
            5'd15: v = 64'd25931;
            5'd16: v = 64'd1441;
            5'd17: v = 64'd76;
            5'd18: v = 64'd4;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    // Rounds a Q58 value to nearest Q23, ties toward plus infinity.
    function automatic logic signed [SUM_W-1:0] q58_to_q23(input logic [63:0] q);
        logic signed [63:0] r;
        r = $signed(q + ROUND_Q58_TO_Q23) >>> 35;
        return r[SUM_W-1:0];
    endfunction

endpackage

// File: design/fixed_point_exp_taylor.sv
// Top level of the fixed-point exponential: e^x in Q8.23 from x in Q4.28 by Taylor series.
// A new input is accepted only once the previous item has finished; the loop sums 1 to MAX_TERMS
// terms, and each term takes four products for the table multiply and two for the power update
// on the single 33x33 multiplier, plus accumulate and update steps.
// A finished result waits in the output register while the next item is accepted.
// Reset clears the sequencer and output valid; datapath registers are not reset.
module fixed_point_exp_taylor
    import fpexp_pkg::*;
#(
    parameter int MAX_TERMS = 19
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [X_W-1:0] exponent_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [RES_W-1:0]      exp_result
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    fpexp_seq #(
        .MAX_TERMS (MAX_TERMS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    fpexp_datapath u_dp (
        .clk            (clk),
        .exponent_value (exponent_value),
        .ctrl           (ctrl),
        .stat           (stat),
        .exp_result     (exp_result)
    );

endmodule

// File: design/fpexp_seq.sv
// Microcode sequencer: program counter, term counter, handshake control and output valid.
module fpexp_seq
    import fpexp_pkg::*;
#(
    parameter int MAX_TERMS = 19
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    localparam logic [K_W-1:0] LAST_K = K_W'(MAX_TERMS - 1);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic [K_W-1:0]  k_reg, k_next;
    logic            run_reg, run_next;
    logic            out_valid_reg, out_valid_next;
    ucode_t          word;
    logic            start;
    logic            finish;

    assign word     = ucode_rom(pc_reg);
    assign in_stall = run_reg;
    assign start    = in_valid && !run_reg;
    assign finish   = run_reg && (word.jmp == J_END) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        pc_next        = pc_reg;
        k_next         = k_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (start)
        begin
            pc_next  = '0;
            k_next   = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            unique case (word.jmp)
                J_NEXT:
                begin
                    pc_next = pc_reg + 1'b1;
                end
                J_TERM:
                begin
                    if (stat.small_term || (k_reg == LAST_K))
                    begin
                        pc_next = DONE_PC;
                    end
                    else
                    begin
                        pc_next = LOOP_PC;
                        k_next  = k_reg + 1'b1;
                    end
                end
                J_END:
                begin
                    if (finish)
                    begin
                        run_next       = 1'b0;
                        out_valid_next = 1'b1;
                    end
                end
                default:
                begin
                    pc_next = pc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            k_reg         <= '0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            k_reg         <= k_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        ctrl.load_x   = start;
        ctrl.load_out = finish;
        ctrl.term_idx = k_reg;
        ctrl.uc       = run_reg ? word : UC_IDLE;
    end

endmodule

// File: design/fpexp_datapath.sv
// Datapath: input clamp, shared 33x33 multiplier, product accumulator, power and sum registers.
module fpexp_datapath
    import fpexp_pkg::*;
(
    input  logic                  clk,
    input  logic signed [X_W-1:0] exponent_value,
    input  dp_ctrl_t              ctrl,
    output dp_stat_t              stat,
    output logic [RES_W-1:0]      exp_result
);

    logic signed [X_W-1:0]   x_reg, x_next;
    logic signed [P_W-1:0]   p_reg, p_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [PP_W-1:0]  pp_reg, pp_next;
    logic                    small_reg, small_next;
    logic [RES_W-1:0]        res_reg, res_next;

    logic signed [63:0]      x_round;
    logic [63:0]             tab;
    logic signed [MUL_W-1:0] a_op, b_op;
    logic [ACC_W-1:0]        pp_ext, pp_shift;
    logic [63:0]             q_init, q_term;
    logic [P_W-1:0]          p_upd;

    always_comb
    begin
        if (exponent_value > X_LIMIT)
        begin
            x_next = X_LIMIT;
        end
        else if (exponent_value < -X_LIMIT)
        begin
            x_next = -X_LIMIT;
        end
        else
        begin
            x_next = exponent_value;
        end
        if (!ctrl.load_x)
        begin
            x_next = x_reg;
        end
    end

    assign tab = inv_fact_q63(ctrl.term_idx);

    always_comb
    begin
        unique case (ctrl.uc.a_sel)
            A_LO: a_op = $signed({1'b0, p_reg[31:0]});
            A_HI: a_op = $signed({p_reg[63], p_reg[63:32]});
            default: a_op = '0;
        endcase
        unique case (ctrl.uc.b_sel)
            B_X:   b_op = $signed({x_reg[31], x_reg});
            B_TLO: b_op = $signed({1'b0, tab[31:0]});
            B_THI: b_op = $signed({1'b0, tab[63:32]});
            default: b_op = '0;
        endcase
    end

    assign pp_next = a_op * b_op;
    assign pp_ext  = {{(ACC_W - PP_W){pp_reg[PP_W-1]}}, pp_reg};

    always_comb
    begin
        unique case (ctrl.uc.acc_sh)
            SH0:  pp_shift = pp_ext;
            SH32: pp_shift = pp_ext << 32;
            SH64: pp_shift = pp_ext << 64;
            default: pp_shift = pp_ext;
        endcase
        unique case (ctrl.uc.acc_op)
            ACC_HOLD: acc_next = acc_reg;
            ACC_CLR:  acc_next = pp_shift;
            ACC_ADD:  acc_next = acc_reg + pp_shift;
            default:  acc_next = acc_reg;
        endcase
    end

    // Multiplying by one half in Q63 and shifting right 18 is a left shift by 44.
    assign x_round = {{32{x_reg[31]}}, x_reg} + P_ROUND;
    assign q_init  = p_reg << 44;
    assign q_term  = acc_reg[82:19];
    assign p_upd   = acc_reg[91:28] + {63'd0, acc_reg[27]};

    always_comb
    begin
        p_next     = p_reg;
        sum_next   = sum_reg;
        small_next = small_reg;
        unique case (ctrl.uc.op)
            OP_NOP:
            begin
                p_next = p_reg;
            end
            OP_PINIT:
            begin
                p_next = x_round >>> 14;
            end
            OP_SUMINIT:
            begin
                sum_next = $signed(ONE_Q23[SUM_W-1:0]) + q58_to_q23(q_init);
            end
            OP_TERM:
            begin
                sum_next   = sum_reg + q58_to_q23(q_term);
                small_next = ($signed(q_term) < STOP_THRESHOLD)
                          && ($signed(q_term) > -STOP_THRESHOLD);
            end
            OP_PUPD:
            begin
                p_next = $signed(p_upd);
            end
            default:
            begin
                p_next = p_reg;
            end
        endcase
    end

    always_comb
    begin
        res_next = res_reg;
        if (ctrl.load_out)
        begin
            if (sum_reg[SUM_W-1])
            begin
                res_next = '0;
            end
            else if (|sum_reg[SUM_W-2:RES_W])
            begin
                res_next = '1;
            end
            else
            begin
                res_next = sum_reg[RES_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        p_reg     <= p_next;
        sum_reg   <= sum_next;
        acc_reg   <= acc_next;
        pp_reg    <= pp_next;
        small_reg <= small_next;
        res_reg   <= res_next;
    end

    assign stat.small_term = small_reg;
    assign exp_result      = res_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the Taylor-series fixed-point exponential unit.
`timescale 1ns / 1ps

module tb_top;
    import fpexp_pkg::X_W;
    import fpexp_pkg::RES_W;
    import fpexp_pkg::X_LIMIT;

    localparam int TERMS_CAP = 19;
    localparam int FACT_LEN  = 19;
    localparam int RAND_N    = 1800;
    localparam int DIR_N     = 18;

    localparam logic signed [63:0] ONE_Q23    = 64'sh0000_0000_0080_0000;
    localparam logic signed [63:0] HALF_Q23   = 64'sh0000_0004_0000_0000;
    localparam logic signed [63:0] TERM_FLOOR = 64'sh0000_1A36_E2EB_4000;
    localparam logic [63:0]        HALF_Q63   = 64'h4000_0000_0000_0000;
    localparam logic [RES_W-1:0]   RES_MAX    = 31'h7FFF_FFFF;

    localparam logic [63:0] INV_FACT [FACT_LEN] = '{
        64'd4611686018427387904, 64'd1537228672809129301, 64'd384307168202282325,
        64'd76861433640456465, 64'd12810238940076077, 64'd1830034134296582,
        64'd228754266787072, 64'd25417140754119, 64'd2541714075411,
        64'd231064915946, 64'd19255409662, 64'd1481185358,
        64'd105798954, 64'd7053264, 64'd440829,
        64'd25931, 64'd1441, 64'd76,
        64'd4
    };

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic                  typed;
        logic [RES_W-1:0]      res;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{32'sh0000_0000, 1'b1, 31'h0080_0000},
        '{32'sh7FFF_FFFF, 1'b0, 31'h0},
        '{32'sh8000_0000, 1'b0, 31'h0},
        '{32'sh5000_0000, 1'b0, 31'h0},
        '{32'shB000_0000, 1'b0, 31'h0},
        '{32'sh5000_0001, 1'b0, 31'h0},
        '{32'shAFFF_FFFF, 1'b0, 31'h0},
        '{32'sh4FFF_FFFF, 1'b0, 31'h0},
        '{32'sh1000_0000, 1'b0, 31'h0},
        '{32'shF000_0000, 1'b0, 31'h0},
        '{32'sh2800_0000, 1'b0, 31'h0},
        '{32'shD800_0000, 1'b0, 31'h0},
        '{32'sh0000_2000, 1'b0, 31'h0},
        '{32'shFFFF_E000, 1'b0, 31'h0},
        '{32'sh0000_1FFF, 1'b0, 31'h0},
        '{32'shFFFF_DFFF, 1'b0, 31'h0},
        '{32'sh0000_0001, 1'b0, 31'h0},
        '{32'shFFFF_FFFF, 1'b0, 31'h0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [X_W-1:0] exponent_value;
    logic                  out_valid;
    logic                  out_stall;
    logic [RES_W-1:0]      exp_result;

    logic             quiet;
    logic             cur_typed;
    logic [RES_W-1:0] cur_res;
    logic [RES_W-1:0] exp_due_q [$];
    int               err_cnt = 0;

    fixed_point_exp_taylor #(
        .MAX_TERMS(TERMS_CAP)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .exponent_value (exponent_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .exp_result     (exp_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [63:0] q58_round(input logic signed [63:0] q);
        logic signed [63:0] t;
        t = q + HALF_Q23;
        return t >>> 35;
    endfunction

    function automatic logic signed [63:0] power_next(input logic signed [63:0] p,
                                                      input logic signed [63:0] x);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] prod;
        a = p;
        b = x;
        prod = a * b;
        return prod[91:28] + {63'd0, prod[27]};
    endfunction

    function automatic logic [RES_W-1:0] exp_taylor_q23(input logic signed [X_W-1:0] xin);
        logic signed [63:0]  x;
        logic signed [63:0]  p;
        logic signed [63:0]  q;
        logic signed [63:0]  sum;
        logic signed [63:0]  mag;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] prod;
        int                  k;
        logic                done;
        x = xin;
        if (x > X_LIMIT)
            x = X_LIMIT;
        if (x < -X_LIMIT)
            x = -X_LIMIT;
        p = (x + 64'sd8192) >>> 14;
        a = p;
        b = $signed({64'd0, HALF_Q63});
        prod = a * b;
        q = prod[81:18];
        sum = ONE_Q23 + q58_round(q);
        p = power_next(p, x);
        k = 0;
        done = 1'b0;
        while (!done && k < TERMS_CAP && k < FACT_LEN)
        begin
            a = p;
            b = $signed({64'd0, INV_FACT[k]});
            prod = a * b;
            q = prod[82:19];
            sum = sum + q58_round(q);
            p = power_next(p, x);
            mag = (q < 0) ? -q : q;
            done = (mag < TERM_FLOOR);
            k++;
        end
        if (sum < 0)
            return '0;
        if (sum > 64'sh7FFF_FFFF)
            return RES_MAX;
        return sum[RES_W-1:0];
    endfunction

    function automatic logic signed [X_W-1:0] rand_exponent();
        longint v;
        case ($urandom_range(0, 9))
            0, 1: v = longint'($urandom);
            2, 3, 4, 5: v = longint'($urandom_range(0, 32'd2684354560)) - 64'sd1342177280;
            6, 7: v = longint'($urandom_range(0, 32'h0100_0000));
            default: v = 64'sd1342177280 - 64'sd4096 + longint'($urandom_range(0, 8192));
        endcase
        if ($urandom_range(0, 1) == 0)
            v = -v;
        return v[X_W-1:0];
    endfunction

    task automatic put_item(input logic signed [X_W-1:0] x, input logic typed,
                            input logic [RES_W-1:0] res);
        int gap;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        exponent_value <= x;
        cur_typed      <= typed;
        cur_res        <= res;
        do @(posedge clk); while (in_stall);
    endtask

    // Expectations are queued at the input transfer and matched in order at the output.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            exp_due_q.push_back(cur_typed ? cur_res : exp_taylor_q23(exponent_value));
        if (rst_n && out_valid && !out_stall)
        begin
            if (exp_due_q.size() == 0)
            begin
                $error("exp_result: unexpected transfer, actual %h", exp_result);
                err_cnt++;
            end
            else
            begin
                if (exp_result !== exp_due_q[0])
                begin
                    $error("exp_result: expected %h, actual %h", exp_due_q[0], exp_result);
                    err_cnt++;
                end
                void'(exp_due_q.pop_front());
            end
        end
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 7) == 0)
                repeat ($urandom_range(40, 200)) @(negedge clk) out_stall <= 1'b0;
            else
                repeat ($urandom_range(1, 12)) @(negedge clk) out_stall <= 1'b0;
            if (!quiet)
                repeat ($urandom_range(1, 7)) @(negedge clk) out_stall <= 1'b1;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        exponent_value = '0;
        quiet          = 1'b0;
        cur_typed      = 1'b0;
        cur_res        = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        foreach (DIR_ROWS[i])
            put_item(DIR_ROWS[i].x, DIR_ROWS[i].typed, DIR_ROWS[i].res);
        for (int i = 0; i < RAND_N; i++)
        begin
            if (i == RAND_N * 7 / 8)
                quiet = 1'b1;
            put_item(rand_exponent(), 1'b0, '0);
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (exp_due_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// File: filelist.f
design/fpexp_pkg.sv
design/fpexp_seq.sv
design/fpexp_datapath.sv
design/fixed_point_exp_taylor.sv
tb/tb_top.sv
